[rtl/core/cor0_pkg.sv]
// Shared types, opcodes and power-up values for the row-0 opcode execute core.
package cor0_pkg;

  typedef enum logic [3:0] {
    OP_NOP        = 4'h0,
    OP_LD_BC_D16  = 4'h1,
    OP_LD_MBC_A   = 4'h2,
    OP_INC_BC     = 4'h3,
    OP_INC_B      = 4'h4,
    OP_DEC_B      = 4'h5,
    OP_LD_B_D8    = 4'h6,
    OP_RLCA       = 4'h7,
    OP_LD_MA16_SP = 4'h8,
    OP_ADD_HL_BC  = 4'h9,
    OP_LD_A_MBC   = 4'hA,
    OP_DEC_BC     = 4'hB,
    OP_INC_C      = 4'hC,
    OP_DEC_C      = 4'hD,
    OP_LD_C_D8    = 4'hE,
    OP_RRCA       = 4'hF
  } opcode_t;

  localparam int unsigned FLAG_Z = 7;
  localparam int unsigned FLAG_N = 6;
  localparam int unsigned FLAG_H = 5;
  localparam int unsigned FLAG_C = 4;

  localparam logic [7:0]  RST_A  = 8'h01;
  localparam logic [7:0]  RST_F  = 8'hB0;
  localparam logic [15:0] RST_BC = 16'h0013;
  localparam logic [15:0] RST_HL = 16'h014D;
  localparam logic [15:0] RST_SP = 16'hFFFE;
  localparam logic [15:0] RST_PC = 16'h0100;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  f;
    logic [15:0] bc;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
  } cpu_state_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  a;
    logic [7:0]  f;
    logic [15:0] bc;
    logic [15:0] hl;
    logic [15:0] pc;
    logic        last;
  } result_t;

endpackage

[rtl/core/cor0_exec.sv]
// Combinational execute of one opcode: next register state and its result requests.
module cor0_exec
  import cor0_pkg::*;
(
  input  cpu_state_t  state,
  input  logic [3:0]  operation,
  input  logic [15:0] immediate,
  input  logic [7:0]  load_data,
  output cpu_state_t  state_nxt,
  output result_t     res0,
  output result_t     res1,
  output logic        two_results
);

  logic [7:0]  b;
  logic [7:0]  c;
  logic [7:0]  b_inc;
  logic [7:0]  b_dec;
  logic [7:0]  c_inc;
  logic [7:0]  c_dec;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  logic [1:0]  pc_len;
  logic        wr;
  logic [15:0] waddr;
  logic [7:0]  wdata;
  logic [15:0] imm_next;

  assign b        = state.bc[15:8];
  assign c        = state.bc[7:0];
  assign b_inc    = b + 8'd1;
  assign b_dec    = b - 8'd1;
  assign c_inc    = c + 8'd1;
  assign c_dec    = c - 8'd1;
  assign hl_sum   = {1'b0, state.hl} + {1'b0, state.bc};
  assign hl_half  = {1'b0, state.hl[11:0]} + {1'b0, state.bc[11:0]};
  assign imm_next = immediate + 16'd1;

  always_comb begin
    state_nxt   = state;
    pc_len      = 2'd1;
    wr          = 1'b0;
    waddr       = 16'h0000;
    wdata       = 8'h00;
    two_results = 1'b0;
    case (opcode_t'(operation))
      OP_NOP: begin
      end
      OP_LD_BC_D16: begin
        state_nxt.bc = immediate;
        pc_len       = 2'd3;
      end
      OP_LD_MBC_A: begin
        wr    = 1'b1;
        waddr = state.bc;
        wdata = state.a;
      end
      OP_INC_BC: state_nxt.bc = state.bc + 16'd1;
      OP_INC_B: begin
        state_nxt.bc          = {b_inc, c};
        state_nxt.f[FLAG_N]   = 1'b0;
        state_nxt.f[FLAG_H]   = (b[3:0] == 4'hF);
        state_nxt.f[FLAG_Z]   = (b_inc == 8'h00);
      end
      OP_DEC_B: begin
        state_nxt.bc          = {b_dec, c};
        state_nxt.f[FLAG_N]   = 1'b1;
        state_nxt.f[FLAG_H]   = (b[3:0] == 4'h0);
        state_nxt.f[FLAG_Z]   = (b_dec == 8'h00);
      end
      OP_LD_B_D8: begin
        state_nxt.bc = {immediate[7:0], c};
        pc_len       = 2'd2;
      end
      OP_RLCA: begin
        state_nxt.a = {state.a[6:0], state.a[7]};
        state_nxt.f = {3'b000, state.a[7], state.f[3:0]};
      end
      OP_LD_MA16_SP: begin
        pc_len      = 2'd3;
        two_results = 1'b1;
        wr          = 1'b1;
        waddr       = immediate;
        wdata       = state.sp[7:0];
      end
      OP_ADD_HL_BC: begin
        state_nxt.hl        = hl_sum[15:0];
        state_nxt.f[FLAG_C] = hl_sum[16];
        state_nxt.f[FLAG_H] = hl_half[12];
        state_nxt.f[FLAG_N] = 1'b0;
      end
      OP_LD_A_MBC: state_nxt.a = load_data;
      OP_DEC_BC: state_nxt.bc = state.bc - 16'd1;
      OP_INC_C: begin
        state_nxt.bc          = {b, c_inc};
        state_nxt.f[FLAG_N]   = 1'b0;
        state_nxt.f[FLAG_H]   = (c[3:0] == 4'hF);
        state_nxt.f[FLAG_Z]   = (c_inc == 8'h00);
      end
      OP_DEC_C: begin
        state_nxt.bc          = {b, c_dec};
        state_nxt.f[FLAG_N]   = 1'b1;
        state_nxt.f[FLAG_H]   = (c[3:0] == 4'h0);
        state_nxt.f[FLAG_Z]   = (c_dec == 8'h00);
      end
      OP_LD_C_D8: begin
        state_nxt.bc = {b, immediate[7:0]};
        pc_len       = 2'd2;
      end
      OP_RRCA: begin
        state_nxt.a = {state.a[0], state.a[7:1]};
        state_nxt.f = {3'b000, state.a[0], state.f[3:0]};
      end
      default: begin
      end
    endcase
    state_nxt.pc = state.pc + {14'd0, pc_len};
  end

  always_comb begin
    res0.mem_write   = wr;
    res0.mem_address = waddr;
    res0.mem_data    = wdata;
    res0.a           = state_nxt.a;
    res0.f           = state_nxt.f;
    res0.bc          = state_nxt.bc;
    res0.hl          = state_nxt.hl;
    res0.pc          = state_nxt.pc;
    res0.last        = !two_results;

    res1             = res0;
    res1.mem_write   = 1'b1;
    res1.mem_address = imm_next;
    res1.mem_data    = state.sp[15:8];
    res1.last        = 1'b1;
  end

endmodule

[rtl/core/cpu_opcode_row0_execute_core.sv]
// Top level: register file, execute logic and result queue for opcodes 0x00-0x0F.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_operation, in_immediate, in_load_data
//   out_    | output    | out_valid/out_stall | out_mem_*, out_a, out_f, out_bc, out_hl,
//           |           |                     | out_pc, out_last
//
// One instruction is accepted per cycle while in_stall is low; its results enter a
// four-entry queue on that edge and reach the outputs behind earlier requests.
// LD (a16),SP produces two requests, every other opcode one; the queue drains
// one request per cycle while out_stall is low.
// Reset loads the power-up register values and empties the queue.
// in_stall is high while the queue holds three or more requests.
module cpu_opcode_row0_execute_core
  import cor0_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [15:0] in_immediate,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_mem_write,
  output logic [15:0] out_mem_address,
  output logic [7:0]  out_mem_data,
  output logic [7:0]  out_a,
  output logic [7:0]  out_f,
  output logic [15:0] out_bc,
  output logic [15:0] out_hl,
  output logic [15:0] out_pc,
  output logic        out_last
);

  cpu_state_t          state_r;
  cpu_state_t          state_nxt;
  result_t             res0;
  result_t             res1;
  logic                two_results;
  result_t             queue_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_nxt;
  logic [QPTR_W-1:0]   wr_ptr_p1;
  logic [QCNT_W-1:0]   push_n;
  logic                push;
  logic                pop;
  result_t             head;

  cor0_exec u_exec (
    .state       (state_r),
    .operation   (in_operation),
    .immediate   (in_immediate),
    .load_data   (in_load_data),
    .state_nxt   (state_nxt),
    .res0        (res0),
    .res1        (res1),
    .two_results (two_results)
  );

  assign in_stall  = (cnt_r > QCNT_W'(QDEPTH - 2));
  assign push      = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);
  assign push_n    = push ? (two_results ? QCNT_W'(2) : QCNT_W'(1)) : '0;
  assign wr_ptr_nxt = wr_ptr_r + push_n[QPTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + (pop ? QPTR_W'(1) : '0);
  assign cnt_nxt    = cnt_r + push_n - (pop ? QCNT_W'(1) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.a  <= RST_A;
      state_r.f  <= RST_F;
      state_r.bc <= RST_BC;
      state_r.hl <= RST_HL;
      state_r.sp <= RST_SP;
      state_r.pc <= RST_PC;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (push) begin
        state_r <= state_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= res0;
      if (two_results) begin
        queue_r[wr_ptr_p1] <= res1;
      end
    end
  end

  assign head            = queue_r[rd_ptr_r];
  assign out_mem_write   = head.mem_write;
  assign out_mem_address = head.mem_address;
  assign out_mem_data    = head.mem_data;
  assign out_a           = head.a;
  assign out_f           = head.f;
  assign out_bc          = head.bc;
  assign out_hl          = head.hl;
  assign out_pc          = head.pc;
  assign out_last        = head.last;

endmodule

[dv/cpu_opcode_row0_execute_core_tb.sv]
// Testbench for the row-0 opcode execute core: directed table and random requests, each checked.
module cpu_opcode_row0_execute_core_tb;
  import cor0_pkg::*;

  localparam int NUM_DIRECTED   = 27;
  localparam int PHASE_REQUESTS = 415;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    opcode_t     op;
    logic [15:0] imm;
    logic [7:0]  ld;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_operation;
  logic [15:0] in_immediate;
  logic [7:0]  in_load_data;
  logic        out_valid;
  logic        out_stall;
  logic        out_mem_write;
  logic [15:0] out_mem_address;
  logic [7:0]  out_mem_data;
  logic [7:0]  out_a;
  logic [7:0]  out_f;
  logic [15:0] out_bc;
  logic [15:0] out_hl;
  logic [15:0] out_pc;
  logic        out_last;

  logic [7:0]  cur_a;
  logic [7:0]  cur_f;
  logic [15:0] cur_bc;
  logic [15:0] cur_hl;
  logic [15:0] cur_sp;
  logic [15:0] cur_pc;

  result_t     retire_q[$];
  stim_row_t   directed_rows [NUM_DIRECTED];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_request;
  int          hold_left;

  cpu_opcode_row0_execute_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_immediate    (in_immediate),
    .in_load_data    (in_load_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mem_write   (out_mem_write),
    .out_mem_address (out_mem_address),
    .out_mem_data    (out_mem_data),
    .out_a           (out_a),
    .out_f           (out_f),
    .out_bc          (out_bc),
    .out_hl          (out_hl),
    .out_pc          (out_pc),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] bump8(input logic [7:0] v, input bit down);
    logic [7:0] r;
    r = down ? v - 8'd1 : v + 8'd1;
    cur_f[FLAG_N] = down;
    cur_f[FLAG_H] = down ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
    cur_f[FLAG_Z] = (r == 8'h00);
    return r;
  endfunction

  function automatic result_t snapshot(input bit wr, input logic [15:0] addr,
                                       input logic [7:0] data, input bit fin);
    result_t res;
    res.mem_write   = wr;
    res.mem_address = wr ? addr : 16'h0000;
    res.mem_data    = wr ? data : 8'h00;
    res.a           = cur_a;
    res.f           = cur_f;
    res.bc          = cur_bc;
    res.hl          = cur_hl;
    res.pc          = cur_pc;
    res.last        = fin;
    return res;
  endfunction

  task automatic execute_opcode(input opcode_t op, input logic [15:0] imm,
                                input logic [7:0] ld);
    logic [7:0]  b;
    logic [7:0]  c;
    logic [16:0] sum;
    logic [12:0] half;
    logic [15:0] len;
    bit          wr;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic        rot;
    b     = cur_bc[15:8];
    c     = cur_bc[7:0];
    len   = 16'd1;
    wr    = 1'b0;
    waddr = 16'h0000;
    wdata = 8'h00;
    case (op)
      OP_NOP: ;
      OP_LD_BC_D16: begin
        cur_bc = imm;
        len    = 16'd3;
      end
      OP_LD_MBC_A: begin
        wr    = 1'b1;
        waddr = cur_bc;
        wdata = cur_a;
      end
      OP_INC_BC: cur_bc = cur_bc + 16'd1;
      OP_INC_B: begin
        b      = bump8(b, 1'b0);
        cur_bc = {b, c};
      end
      OP_DEC_B: begin
        b      = bump8(b, 1'b1);
        cur_bc = {b, c};
      end
      OP_LD_B_D8: begin
        cur_bc = {imm[7:0], c};
        len    = 16'd2;
      end
      OP_RLCA: begin
        rot   = cur_a[7];
        cur_a = {cur_a[6:0], rot};
        cur_f = {3'b000, rot, cur_f[3:0]};
      end
      OP_LD_MA16_SP: begin
        cur_pc = cur_pc + 16'd3;
        retire_q.push_back(snapshot(1'b1, imm, cur_sp[7:0], 1'b0));
        retire_q.push_back(snapshot(1'b1, imm + 16'd1, cur_sp[15:8], 1'b1));
        return;
      end
      OP_ADD_HL_BC: begin
        sum           = {1'b0, cur_hl} + {1'b0, cur_bc};
        half          = {1'b0, cur_hl[11:0]} + {1'b0, cur_bc[11:0]};
        cur_f[FLAG_C] = sum[16];
        cur_f[FLAG_H] = half[12];
        cur_f[FLAG_N] = 1'b0;
        cur_hl        = sum[15:0];
      end
      OP_LD_A_MBC: cur_a = ld;
      OP_DEC_BC: cur_bc = cur_bc - 16'd1;
      OP_INC_C: begin
        c      = bump8(c, 1'b0);
        cur_bc = {b, c};
      end
      OP_DEC_C: begin
        c      = bump8(c, 1'b1);
        cur_bc = {b, c};
      end
      OP_LD_C_D8: begin
        cur_bc = {b, imm[7:0]};
        len    = 16'd2;
      end
      default: begin
        rot   = cur_a[0];
        cur_a = {rot, cur_a[7:1]};
        cur_f = {3'b000, rot, cur_f[3:0]};
      end
    endcase
    cur_pc = cur_pc + len;
    retire_q.push_back(snapshot(wr, waddr, wdata, 1'b1));
  endtask

  task automatic send_request(input opcode_t op, input logic [15:0] imm,
                              input logic [7:0] ld, input bit typed,
                              input result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_operation <= 4'($urandom_range(15));
      in_immediate <= 16'($urandom);
      in_load_data <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_immediate <= imm;
    in_load_data <= ld;
    do @(posedge clk); while (in_stall);
    execute_opcode(op, imm, ld);
    if (typed) begin
      void'(retire_q.pop_back());
      retire_q.push_back(typed_res);
    end
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (retire_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = retire_q.pop_front();
        check_field("mem_write", 16'(out_mem_write), 16'(want.mem_write));
        check_field("mem_address", out_mem_address, want.mem_address);
        check_field("mem_data", 16'(out_mem_data), 16'(want.mem_data));
        check_field("a", 16'(out_a), 16'(want.a));
        check_field("f", 16'(out_f), 16'(want.f));
        check_field("bc", out_bc, want.bc);
        check_field("hl", out_hl, want.hl);
        check_field("pc", out_pc, want.pc);
        check_field("last", 16'(out_last), 16'(want.last));
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [15:0] imm;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = 4'h0;
    in_immediate   = 16'h0000;
    in_load_data   = 8'h00;
    out_stall      = 1'b0;
    mismatches     = 0;
    hold_request   = 1'b0;
    hold_left      = 0;
    send_idle_pct  = 13;
    recv_stall_pct = 74;
    cur_a          = RST_A;
    cur_f          = RST_F;
    cur_bc         = RST_BC;
    cur_hl         = RST_HL;
    cur_sp         = RST_SP;
    cur_pc         = RST_PC;
    directed_rows = '{
      '{OP_NOP,        16'h0000, 8'h00, 1'b1,
        '{1'b0, 16'h0000, 8'h00, 8'h01, 8'hB0, 16'h0013, 16'h014D, 16'h0101, 1'b1}},
      '{OP_LD_BC_D16,  16'hFFFF, 8'h00, 1'b1,
        '{1'b0, 16'h0000, 8'h00, 8'h01, 8'hB0, 16'hFFFF, 16'h014D, 16'h0104, 1'b1}},
      '{OP_INC_BC,     16'h0000, 8'h00, 1'b1,
        '{1'b0, 16'h0000, 8'h00, 8'h01, 8'hB0, 16'h0000, 16'h014D, 16'h0105, 1'b1}},
      '{OP_DEC_BC,     16'h0000, 8'h00, 1'b1,
        '{1'b0, 16'h0000, 8'h00, 8'h01, 8'hB0, 16'hFFFF, 16'h014D, 16'h0106, 1'b1}},
      '{OP_INC_B,      16'h0000, 8'h00, 1'b1,
        '{1'b0, 16'h0000, 8'h00, 8'h01, 8'hB0, 16'h00FF, 16'h014D, 16'h0107, 1'b1}},
      '{OP_DEC_B,      16'h0000, 8'h00, 1'b1,
        '{1'b0, 16'h0000, 8'h00, 8'h01, 8'h70, 16'hFFFF, 16'h014D, 16'h0108, 1'b1}},
      '{OP_LD_B_D8,    16'hA50F, 8'h00, 1'b0, '0},
      '{OP_INC_B,      16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_C_D8,    16'h5AFF, 8'h00, 1'b0, '0},
      '{OP_INC_C,      16'h0000, 8'h00, 1'b0, '0},
      '{OP_DEC_C,      16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_C_D8,    16'h0001, 8'h00, 1'b0, '0},
      '{OP_DEC_C,      16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_A_MBC,   16'h0000, 8'h80, 1'b0, '0},
      '{OP_RLCA,       16'h0000, 8'h00, 1'b0, '0},
      '{OP_RRCA,       16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_A_MBC,   16'h0000, 8'h00, 1'b0, '0},
      '{OP_RLCA,       16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_MA16_SP, 16'hFFFF, 8'h00, 1'b0, '0},
      '{OP_LD_MBC_A,   16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_BC_D16,  16'h0FFF, 8'h00, 1'b0, '0},
      '{OP_ADD_HL_BC,  16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_BC_D16,  16'hFFFF, 8'h00, 1'b0, '0},
      '{OP_ADD_HL_BC,  16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_MA16_SP, 16'h0000, 8'h00, 1'b0, '0},
      '{OP_LD_A_MBC,   16'h0000, 8'hFF, 1'b0, '0},
      '{OP_LD_MBC_A,   16'h0000, 8'h00, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].imm, directed_rows[i].ld,
                   directed_rows[i].typed, directed_rows[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 13;
          recv_stall_pct = 74;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
      endcase
      repeat (PHASE_REQUESTS) begin
        case ($urandom_range(15))
          0: imm = 16'h0000;
          1: imm = 16'hFFFF;
          2: imm = 16'h00FF;
          3: imm = 16'hFF00;
          4: imm = 16'h0FFF;
          default: imm = 16'($urandom);
        endcase
        send_request(opcode_t'($urandom_range(15)), imm, 8'($urandom_range(255)),
                     1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
